### rtl/milt_pkg.sv
// message id lookup table: shared types and constants
// no dependencies; used by every module in rtl
package milt_pkg;

   localparam int KEY_W   = 160;
   localparam int VALUE_W = 10;
   localparam int COUNT_W = 7;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_LOOKUP = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_SEARCH  = 5'b00010,
      ST_EVAL    = 5'b00100,
      ST_COMPACT = 5'b01000,
      ST_COUNT   = 5'b10000
   } state_type;

   typedef struct packed {
      logic                compact;
      logic                phase;
      logic                clear_hits;
      logic                write_en;
      logic [KEY_W-1:0]    key;
      logic [VALUE_W-1:0]  value;
   } cell_ctl_type;

endpackage

### rtl/milt_cell.sv
// message id lookup table: one table cell (key, value, in-use flag, match flag)
// compares against the broadcast key and trades entries with its neighbors
// depends on milt_pkg
module milt_cell #(
   parameter int IDX       = 0,
   parameter int KEY_BYTES = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  milt_pkg::cell_ctl_type        ctl,
   input  logic                          sel,
   input  logic                          up_used,
   input  logic [milt_pkg::KEY_W-1:0]    up_key,
   input  logic [milt_pkg::VALUE_W-1:0]  up_value,
   input  logic                          down_used,
   output logic                          used,
   output logic [milt_pkg::KEY_W-1:0]    key,
   output logic [milt_pkg::VALUE_W-1:0]  value,
   output logic                          hit
);

   localparam logic [milt_pkg::KEY_W-1:0] MASK =
      ~({milt_pkg::KEY_W{1'b1}} >> (KEY_BYTES * 8));
   localparam logic PARITY = 1'((IDX % 2));

   logic                          used_ff, used_in;
   logic                          hit_ff, hit_in;
   logic [milt_pkg::KEY_W-1:0]    key_ff, key_in;
   logic [milt_pkg::VALUE_W-1:0]  value_ff, value_in;
   logic                          lower_side;

   assign lower_side = (ctl.phase == PARITY);
   assign hit_in     = used_ff && (((key_ff ^ ctl.key) & MASK) == '0);

   always_comb begin
      used_in  = used_ff;
      key_in   = key_ff;
      value_in = value_ff;
      if (ctl.write_en && sel) begin
         used_in  = 1'b1;
         key_in   = ctl.key;
         value_in = ctl.value;
      end else if (ctl.clear_hits && hit_ff) begin
         used_in = 1'b0;
      end else if (ctl.compact) begin
         // odd-even exchange: a hole moves up past a live entry
         if (lower_side) begin
            if (!used_ff && up_used) begin
               used_in  = 1'b1;
               key_in   = up_key;
               value_in = up_value;
            end
         end else if (used_ff && !down_used) begin
            used_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
         hit_ff  <= 1'b0;
      end else begin
         used_ff <= used_in;
         hit_ff  <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign used  = used_ff;
   assign key   = key_ff;
   assign value = value_ff;
   assign hit   = hit_ff;

endmodule

### rtl/milt_select.sv
// message id lookup table: picks the oldest and newest matching cell values
// depends on milt_pkg
module milt_select #(
   parameter int DEPTH = 64
) (
   input  logic [DEPTH-1:0]              hits,
   input  logic [milt_pkg::VALUE_W-1:0]  values [DEPTH],
   output logic                          any_hit,
   output logic [milt_pkg::VALUE_W-1:0]  first_value,
   output logic [milt_pkg::VALUE_W-1:0]  last_value
);

   localparam logic [DEPTH-1:0] ONE = DEPTH'(1);

   logic [DEPTH-1:0] hits_rev;
   logic [DEPTH-1:0] first_oh;
   logic [DEPTH-1:0] last_oh_rev;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         hits_rev[i] = hits[DEPTH-1-i];
      end
   end

   // lowest set bit isolation
   assign first_oh    = hits & (~hits + ONE);
   assign last_oh_rev = hits_rev & (~hits_rev + ONE);
   assign any_hit     = |hits;

   always_comb begin
      first_value = '0;
      last_value  = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (first_oh[i]) begin
            first_value = first_value | values[i];
         end
         if (last_oh_rev[DEPTH-1-i]) begin
            last_value = last_value | values[i];
         end
      end
   end

endmodule

### rtl/message_id_lookup_table_core.sv
// message id lookup table: top level with control sequencer and cell chain
// depends on milt_pkg, milt_cell, milt_select
// insert, lookup and unused mode: busy through the SEARCH and EVAL states, result strobe registered out of EVAL
// delete: busy through SEARCH, EVAL, COMPACT and COUNT (DEPTH odd-even exchange steps across the cell chain)
// a new word is taken in the cycle its predecessor's result strobe is shown
// synchronous reset empties the table; the result strobe is never stalled
module message_id_lookup_table_core #(
   parameter int DEPTH     = 64,
   parameter int KEY_BYTES = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_mode,
   input  logic [31:0]                   req_key_upper,
   input  logic [63:0]                   req_key_middle,
   input  logic [63:0]                   req_key_lower,
   input  logic [milt_pkg::VALUE_W-1:0]  req_conn_value,
   output logic                          rsp_strobe,
   output logic                          rsp_hit,
   output logic [milt_pkg::VALUE_W-1:0]  rsp_first_value,
   output logic [milt_pkg::VALUE_W-1:0]  rsp_last_value,
   output logic                          rsp_dropped,
   output logic [milt_pkg::COUNT_W-1:0]  rsp_removed_count,
   output logic [milt_pkg::COUNT_W-1:0]  rsp_entry_count
);

   localparam int OCC_W = $clog2(DEPTH + 1);
   localparam int CNT_W = $clog2(DEPTH);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DEPTH - 1);
   localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

   milt_pkg::state_type               state_ff, state_in;
   milt_pkg::mode_type                mode_ff, mode_in;
   logic [milt_pkg::KEY_W-1:0]        key_ff, key_in;
   logic [milt_pkg::VALUE_W-1:0]      value_ff, value_in;
   logic [OCC_W-1:0]                  occ_ff, occ_in;
   logic [CNT_W-1:0]                  cnt_ff, cnt_in;

   logic                              strobe_ff, strobe_in;
   logic                              hit_ff, hit_in;
   logic [milt_pkg::VALUE_W-1:0]      first_ff, first_in;
   logic [milt_pkg::VALUE_W-1:0]      last_ff, last_in;
   logic                              dropped_ff, dropped_in;
   logic [milt_pkg::COUNT_W-1:0]      removed_ff, removed_in;
   logic [milt_pkg::COUNT_W-1:0]      entry_ff, entry_in;

   milt_pkg::cell_ctl_type            ctl;
   logic                              accept;

   logic [DEPTH-1:0]                  used_vec;
   logic [DEPTH-1:0]                  hit_vec;
   logic [DEPTH-1:0]                  sel_vec;
   logic [milt_pkg::KEY_W-1:0]        key_w   [DEPTH];
   logic [milt_pkg::VALUE_W-1:0]      value_w [DEPTH];

   logic                              sel_hit;
   logic [milt_pkg::VALUE_W-1:0]      sel_first, sel_last;

   logic [DEPTH:0]                    bound_oh;
   logic [OCC_W-1:0]                  new_occ;

   assign busy   = (state_ff != milt_pkg::ST_IDLE);
   assign accept = start && !busy;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                          up_used;
      logic [milt_pkg::KEY_W-1:0]    up_key;
      logic [milt_pkg::VALUE_W-1:0]  up_value;
      logic                          down_used;

      if (i == DEPTH - 1) begin : g_top
         assign up_used  = 1'b0;
         assign up_key   = '0;
         assign up_value = '0;
      end else begin : g_mid
         assign up_used  = used_vec[i+1];
         assign up_key   = key_w[i+1];
         assign up_value = value_w[i+1];
      end

      if (i == 0) begin : g_bottom
         assign down_used = 1'b1;
      end else begin : g_rest
         assign down_used = used_vec[i-1];
      end

      assign sel_vec[i] = (occ_ff == OCC_W'(i));

      milt_cell #(
         .IDX       (i),
         .KEY_BYTES (KEY_BYTES)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .sel       (sel_vec[i]),
         .up_used   (up_used),
         .up_key    (up_key),
         .up_value  (up_value),
         .down_used (down_used),
         .used      (used_vec[i]),
         .key       (key_w[i]),
         .value     (value_w[i]),
         .hit       (hit_vec[i])
      );
   end

   milt_select #(
      .DEPTH (DEPTH)
   ) u_select (
      .hits        (hit_vec),
      .values      (value_w),
      .any_hit     (sel_hit),
      .first_value (sel_first),
      .last_value  (sel_last)
   );

   // live cells are packed from the bottom after compaction
   assign bound_oh = {1'b0, used_vec} + (DEPTH + 1)'(1);

   always_comb begin
      new_occ = '0;
      for (int i = 0; i <= DEPTH; i++) begin
         if (bound_oh[i]) begin
            new_occ = new_occ | OCC_W'(i);
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      key_in     = key_ff;
      value_in   = value_ff;
      occ_in     = occ_ff;
      cnt_in     = cnt_ff;
      strobe_in  = 1'b0;
      hit_in     = hit_ff;
      first_in   = first_ff;
      last_in    = last_ff;
      dropped_in = dropped_ff;
      removed_in = removed_ff;
      entry_in   = entry_ff;

      ctl.compact    = 1'b0;
      ctl.phase      = cnt_ff[0];
      ctl.clear_hits = 1'b0;
      ctl.write_en   = 1'b0;
      ctl.key        = key_ff;
      ctl.value      = value_ff;

      unique case (state_ff)
         milt_pkg::ST_IDLE: begin
            if (accept) begin
               mode_in  = milt_pkg::mode_type'(req_mode);
               key_in   = {req_key_upper, req_key_middle, req_key_lower};
               value_in = req_conn_value;
               state_in = milt_pkg::ST_SEARCH;
            end
         end
         milt_pkg::ST_SEARCH: begin
            state_in = milt_pkg::ST_EVAL;
         end
         milt_pkg::ST_EVAL: begin
            hit_in     = 1'b0;
            first_in   = '0;
            last_in    = '0;
            dropped_in = 1'b0;
            removed_in = '0;
            entry_in   = milt_pkg::COUNT_W'(occ_ff);
            unique case (mode_ff)
               milt_pkg::MODE_INSERT: begin
                  strobe_in = 1'b1;
                  state_in  = milt_pkg::ST_IDLE;
                  if (occ_ff == OCC_FULL) begin
                     dropped_in = 1'b1;
                  end else begin
                     ctl.write_en = 1'b1;
                     occ_in       = occ_ff + OCC_W'(1);
                     entry_in     = milt_pkg::COUNT_W'(occ_in);
                  end
               end
               milt_pkg::MODE_DELETE: begin
                  ctl.clear_hits = 1'b1;
                  cnt_in         = '0;
                  state_in       = milt_pkg::ST_COMPACT;
               end
               milt_pkg::MODE_LOOKUP: begin
                  strobe_in = 1'b1;
                  state_in  = milt_pkg::ST_IDLE;
                  hit_in    = sel_hit;
                  first_in  = sel_first;
                  last_in   = sel_last;
               end
               milt_pkg::MODE_NONE: begin
                  strobe_in = 1'b1;
                  state_in  = milt_pkg::ST_IDLE;
               end
               default: begin
                  state_in = milt_pkg::ST_IDLE;
               end
            endcase
         end
         milt_pkg::ST_COMPACT: begin
            ctl.compact = 1'b1;
            cnt_in      = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_LAST) begin
               state_in = milt_pkg::ST_COUNT;
            end
         end
         milt_pkg::ST_COUNT: begin
            occ_in     = new_occ;
            removed_in = milt_pkg::COUNT_W'(occ_ff - new_occ);
            entry_in   = milt_pkg::COUNT_W'(new_occ);
            strobe_in  = 1'b1;
            state_in   = milt_pkg::ST_IDLE;
         end
         default: begin
            state_in = milt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= milt_pkg::ST_IDLE;
         occ_ff    <= '0;
         cnt_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         occ_ff    <= occ_in;
         cnt_ff    <= cnt_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      key_ff     <= key_in;
      value_ff   <= value_in;
      hit_ff     <= hit_in;
      first_ff   <= first_in;
      last_ff    <= last_in;
      dropped_ff <= dropped_in;
      removed_ff <= removed_in;
      entry_ff   <= entry_in;
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_hit           = hit_ff;
   assign rsp_first_value   = first_ff;
   assign rsp_last_value    = last_ff;
   assign rsp_dropped       = dropped_ff;
   assign rsp_removed_count = removed_ff;
   assign rsp_entry_count   = entry_ff;

endmodule
